// File: rtl/qrs_pkg.sv
// Shared types, codes and arithmetic step functions of the quadratic root solver.
// No dependencies; every other file of the block refers to this package by scoped names.
package qrs_pkg;

    // Equation class decided by the front part.
    typedef enum logic [4:0] {
        CLS_NONE = 5'b00001,
        CLS_INF  = 5'b00010,
        CLS_LIN  = 5'b00100,
        CLS_DBL  = 5'b01000,
        CLS_TWO  = 5'b10000
    } t_cls;

    // Root count codes on the result channel.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    // Saturation limits of a 32-bit signed root.
    localparam logic [31:0] ROOT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ROOT_MIN = 32'h8000_0000;

    // One classified equation as it waits in the queue.
    typedef struct packed {
        t_cls               cls;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [64:0]        d;
    } t_job;

    // Coefficients and class carried beside the square root stages.
    typedef struct packed {
        t_cls               cls;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } t_coef;

    // Partial state of the digit-by-digit square root.
    typedef struct packed {
        logic [34:0] rem;
        logic [32:0] root;
        logic [65:0] rad;
    } t_sq;

    // Partial state of one restoring divider.
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] nlow;
        logic [31:0] quo;
    } t_dv;

    // Side information carried beside the divider stages.
    typedef struct packed {
        t_cls        cls;
        logic        neg_a;
        logic        neg_b;
        logic        big_a;
        logic        big_b;
        logic [32:0] dm;
    } t_dmeta;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // A coefficient counts as zero when its magnitude is zero or below the tolerance.
    function automatic logic is_small(logic [31:0] x, logic [15:0] tol);
        logic [32:0] m;
        m = x[31] ? (33'd0 - {1'b1, x}) : {1'b0, x};
        return (m == 33'd0) || (m < {17'd0, tol});
    endfunction

    // One result bit of the square root.
    function automatic t_sq sq_step(t_sq x);
        logic [34:0] rem2;
        logic [34:0] trial;
        t_sq         y;
        rem2  = {x.rem[32:0], x.rad[65:64]};
        trial = {x.root, 2'b01};
        y.rad = {x.rad[63:0], 2'b00};
        if (rem2 >= trial) begin
            y.rem  = rem2 - trial;
            y.root = {x.root[31:0], 1'b1};
        end else begin
            y.rem  = rem2;
            y.root = {x.root[31:0], 1'b0};
        end
        return y;
    endfunction

    // One quotient bit of the restoring divider.
    function automatic t_dv dv_step(t_dv x, logic [32:0] dm);
        logic [33:0] rem2;
        t_dv         y;
        rem2   = {x.rem[32:0], x.nlow[31]};
        y.nlow = {x.nlow[30:0], 1'b0};
        if (rem2 >= {1'b0, dm}) begin
            y.rem = rem2 - {1'b0, dm};
            y.quo = {x.quo[30:0], 1'b1};
        end else begin
            y.rem = rem2;
            y.quo = {x.quo[30:0], 1'b0};
        end
        return y;
    endfunction

    // Signs and clamps a quotient magnitude; bit 32 of the result is the overflow flag.
    function automatic logic [32:0] fix_sat(logic [31:0] q, logic big, logic neg);
        logic [32:0] r;
        if (neg) begin
            if (big || (q > ROOT_MIN)) r = {1'b1, ROOT_MIN};
            else                       r = {1'b0, 32'd0 - q};
        end else begin
            if (big || q[31]) r = {1'b1, ROOT_MAX};
            else              r = {1'b0, q};
        end
        return r;
    endfunction

endpackage

// File: rtl/qrs_front.sv
// Front part of the quadratic root solver: takes equations, forms b*b and a*c,
// and classifies each one before it enters the queue. Depends on qrs_pkg.
module qrs_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_coef_quad,
    input  logic signed [31:0]  i_coef_lin,
    input  logic signed [31:0]  i_coef_const,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    input  qrs_pkg::t_qstat     i_qstat,
    output logic                o_push,
    output qrs_pkg::t_job       o_job
);

    logic               r_tol;
    logic [15:0]        r_tol_val;
    logic               r_s1_v;
    logic signed [31:0] r_a1, r_b1, r_c1;
    logic               r_s2_v;
    logic signed [31:0] r_a2, r_b2, r_c2;
    logic [63:0]        r_bb;
    logic signed [63:0] r_ac;
    logic               r_za, r_zb, r_zc;
    logic               s1_adv, s2_adv;
    logic signed [63:0] bb_s;
    logic signed [65:0] ac4, dsc;
    logic [65:0]        dmag, lim;
    logic               dz;
    qrs_pkg::t_cls      cls;

    // Tolerance register; r_tol only marks that a write has been seen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= 1'b0;
            r_tol_val <= 16'd1;
        end else if (i_cfg_valid) begin
            r_tol     <= 1'b1;
            r_tol_val <= i_cfg_data;
        end
    end

    // Each stage moves when it is empty or its successor moves.
    assign s2_adv  = !r_s2_v || !i_qstat.full;
    assign s1_adv  = !r_s1_v || s2_adv;
    assign o_stall = !s1_adv;
    assign o_push  = r_s2_v && !i_qstat.full;

    // Stage one: capture the coefficients of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_adv) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_a1 <= i_coef_quad;
            r_b1 <= i_coef_lin;
            r_c1 <= i_coef_const;
        end
    end

    // Stage two: products and zero tests.
    assign bb_s = r_b1 * r_b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_v) begin
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            r_c2 <= r_c1;
            r_bb <= bb_s;
            r_ac <= r_a1 * r_c1;
            r_za <= qrs_pkg::is_small(r_a1, r_tol_val);
            r_zb <= qrs_pkg::is_small(r_b1, r_tol_val);
            r_zc <= qrs_pkg::is_small(r_c1, r_tol_val);
        end
    end

    // Discriminant d = b*b - 4*a*c with 2*FRAC_BITS fractional bits, and its zero test.
    assign ac4  = {r_ac, 2'b00};
    assign dsc  = $signed({2'b00, r_bb}) - ac4;
    assign dmag = dsc[65] ? (66'd0 - dsc) : dsc;
    assign lim  = 66'(r_tol_val) << FRAC_BITS;
    assign dz   = (dsc == 66'sd0) || (dmag < lim);

    // Classification of the equation.
    always_comb begin
        if (r_za) begin
            if (r_zb) cls = r_zc ? qrs_pkg::CLS_INF : qrs_pkg::CLS_NONE;
            else      cls = qrs_pkg::CLS_LIN;
        end else if (dz) begin
            cls = qrs_pkg::CLS_DBL;
        end else if (!dsc[65]) begin
            cls = qrs_pkg::CLS_TWO;
        end else begin
            cls = qrs_pkg::CLS_NONE;
        end
    end

    assign o_job.cls = cls;
    assign o_job.a   = r_a2;
    assign o_job.b   = r_b2;
    assign o_job.c   = r_c2;
    assign o_job.d   = dmag[64:0];

    // The tolerance flag is kept for the assertion below.
    tol_seen_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid |=> r_tol && (r_tol_val == $past(i_cfg_data))))
        else $error("tolerance register missed a write");

endmodule

// File: rtl/qrs_queue.sv
// Short queue between the front and back parts of the quadratic root solver.
// Depends on qrs_pkg for the entry and status types.
module qrs_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qrs_pkg::t_job   i_job,
    input  logic            i_pop,
    output qrs_pkg::t_job   o_job,
    output qrs_pkg::t_qstat o_qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qrs_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_qstat.full  = (r_cnt == CW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_job         = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    no_overrun_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_qstat.full))
        else $error("queue written while full");

    no_underrun_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_qstat.empty))
        else $error("queue read while empty");

    fill_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

// File: rtl/qrs_back.sv
// Back part of the quadratic root solver: square root, two dividers, saturation and
// the output register. Depends on qrs_pkg.
module qrs_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qrs_pkg::t_job       i_job,
    input  qrs_pkg::t_qstat     i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_root_count,
    output logic signed [31:0]  o_root_first,
    output logic signed [31:0]  o_root_second,
    output logic                o_overflow
);

    localparam int SqN  = 33;
    localparam int DvN  = 32;
    localparam int NW   = 34 + FRAC_BITS;
    localparam int CmpW = (NW > 65) ? NW : 65;

    logic                 en;
    logic                 r_out_v;
    logic [1:0]           r_cnt;
    logic [31:0]          r_r1, r_r2;
    logic                 r_ovf;

    logic                 r_sv [SqN+1];
    qrs_pkg::t_coef       r_sp [SqN+1];
    qrs_pkg::t_sq         r_ss [SqN+1];

    logic                 r_nv;
    qrs_pkg::t_cls        r_ncls;
    logic [33:0]          r_nm_a, r_nm_b;
    logic [32:0]          r_dm;
    logic                 r_neg_a, r_neg_b;

    logic                 r_dv [DvN+1];
    qrs_pkg::t_dmeta      r_dp [DvN+1];
    qrs_pkg::t_dv         r_da [DvN+1];
    qrs_pkg::t_dv         r_db [DvN+1];

    logic signed [34:0]   bx, cx, sx, num_a, num_b;
    logic signed [32:0]   den;
    logic [NW-1:0]        n_a, n_b;
    logic [32:0]          sat_a, sat_b;
    qrs_pkg::t_coef       sp;

    // The whole back pipeline moves when the output register can take a result.
    assign en    = !r_out_v || !i_stall;
    assign o_pop = en && !i_qstat.empty;

    // Square root entry stage, loaded from the queue.
    assign sp = r_sp[SqN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_qstat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp[0].cls <= i_job.cls;
            r_sp[0].a   <= i_job.a;
            r_sp[0].b   <= i_job.b;
            r_sp[0].c   <= i_job.c;
            r_ss[0].rem  <= '0;
            r_ss[0].root <= '0;
            r_ss[0].rad  <= {1'b0, i_job.d};
        end
    end

    // One root bit per stage.
    for (genvar k = 0; k < SqN; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sp[k+1] <= r_sp[k];
                r_ss[k+1] <= qrs_pkg::sq_step(r_ss[k]);
            end
        end
    end

    // Numerators and denominator for the class at hand.
    assign bx = {{3{sp.b[31]}}, sp.b};
    assign cx = {{3{sp.c[31]}}, sp.c};
    assign sx = $signed({2'b00, r_ss[SqN].root});

    always_comb begin
        num_b = sx - bx;
        if (sp.cls == qrs_pkg::CLS_LIN) begin
            num_a = 35'sd0 - cx;
            den   = {sp.b[31], sp.b};
        end else if (sp.cls == qrs_pkg::CLS_TWO) begin
            num_a = 35'sd0 - bx - sx;
            den   = {sp.a, 1'b0};
        end else begin
            num_a = 35'sd0 - bx;
            den   = {sp.a, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (en) begin
            r_nv <= r_sv[SqN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ncls  <= sp.cls;
            r_nm_a  <= num_a[34] ? 34'(35'sd0 - num_a) : num_a[33:0];
            r_nm_b  <= num_b[34] ? 34'(35'sd0 - num_b) : num_b[33:0];
            r_dm    <= den[32] ? (33'd0 - den) : den;
            r_neg_a <= num_a[34] ^ den[32];
            r_neg_b <= num_b[34] ^ den[32];
        end
    end

    // Divider entry: scale the numerators, catch quotients of 2^32 and above.
    assign n_a = {r_nm_a, {FRAC_BITS{1'b0}}};
    assign n_b = {r_nm_b, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp[0].cls   <= r_ncls;
            r_dp[0].neg_a <= r_neg_a;
            r_dp[0].neg_b <= r_neg_b;
            r_dp[0].big_a <= CmpW'(n_a) >= CmpW'({r_dm, 32'd0});
            r_dp[0].big_b <= CmpW'(n_b) >= CmpW'({r_dm, 32'd0});
            r_dp[0].dm    <= r_dm;
            r_da[0].rem   <= 34'(n_a >> 32);
            r_da[0].nlow  <= n_a[31:0];
            r_da[0].quo   <= '0;
            r_db[0].rem   <= 34'(n_b >> 32);
            r_db[0].nlow  <= n_b[31:0];
            r_db[0].quo   <= '0;
        end
    end

    // One quotient bit per stage in each divider.
    for (genvar k = 0; k < DvN; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dp[k+1] <= r_dp[k];
                r_da[k+1] <= qrs_pkg::dv_step(r_da[k], r_dp[k].dm);
                r_db[k+1] <= qrs_pkg::dv_step(r_db[k], r_dp[k].dm);
            end
        end
    end

    // Sign, clamp and select the result fields.
    assign sat_a = qrs_pkg::fix_sat(r_da[DvN].quo, r_dp[DvN].big_a, r_dp[DvN].neg_a);
    assign sat_b = qrs_pkg::fix_sat(r_db[DvN].quo, r_dp[DvN].big_b, r_dp[DvN].neg_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv[DvN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_dp[DvN].cls)
                qrs_pkg::CLS_INF: begin
                    r_cnt <= qrs_pkg::CNT_INF;
                    r_r1  <= '0;
                    r_r2  <= '0;
                    r_ovf <= 1'b0;
                end
                qrs_pkg::CLS_LIN: begin
                    r_cnt <= qrs_pkg::CNT_ONE;
                    r_r1  <= sat_a[31:0];
                    r_r2  <= '0;
                    r_ovf <= sat_a[32];
                end
                qrs_pkg::CLS_DBL: begin
                    r_cnt <= qrs_pkg::CNT_ONE;
                    r_r1  <= sat_a[31:0];
                    r_r2  <= sat_a[31:0];
                    r_ovf <= sat_a[32];
                end
                qrs_pkg::CLS_TWO: begin
                    r_cnt <= qrs_pkg::CNT_TWO;
                    r_r1  <= sat_a[31:0];
                    r_r2  <= sat_b[31:0];
                    r_ovf <= sat_a[32] | sat_b[32];
                end
                default: begin
                    r_cnt <= qrs_pkg::CNT_NONE;
                    r_r1  <= '0;
                    r_r2  <= '0;
                    r_ovf <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid       = r_out_v;
    assign o_root_count  = r_cnt;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;
    assign o_overflow    = r_ovf;

    no_root_clean_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_root_count == qrs_pkg::CNT_NONE || o_root_count == qrs_pkg::CNT_INF))
        |-> (o_root_first == 32'sd0 && o_root_second == 32'sd0 && !o_overflow))
        else $error("unproduced roots are not zero");

endmodule

// File: rtl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: front, queue and back parts.
// Depends on qrs_pkg, qrs_front, qrs_queue and qrs_back.
//
// Usage:
// - Input channel: i_valid with o_stall carries the coefficients a, b and c as signed
//   fixed-point values. A transfer happens when i_valid is high and o_stall is low.
// - Output channel: o_valid with i_stall carries the root count, two roots and the
//   overflow flag, one result for every input transfer, in order.
// - Configuration: i_cfg_valid writes the zero tolerance from i_cfg_data; o_cfg_ready
//   is always high. Write it only while no equation is in flight.
// - Path of an input transfer to o_valid: the first front stage loads at the transfer
//   edge; after it come the second front stage, the queue, the square root entry
//   stage, 33 square root stages, two setup stages, 32 divider stages and the output
//   register.
// - Throughput is one equation per cycle while i_stall is low; every stage of the root
//   and divider pipelines holds its own equation.
// - Reset clears all valid bits and the queue and sets the tolerance to one.
// - When the receiver stalls, the back pipeline holds; the front keeps taking equations
//   until the queue and both front stages are full, then raises o_stall.
module quadratic_root_solver_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_coef_quad,
    input  logic signed [31:0] i_coef_lin,
    input  logic signed [31:0] i_coef_const,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_root_count,
    output logic signed [31:0] o_root_first,
    output logic signed [31:0] o_root_second,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    qrs_pkg::t_qstat qstat;
    qrs_pkg::t_job   push_job, pop_job;
    logic            push, pop;

    assign o_cfg_ready = 1'b1;

    qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_coef_quad  (i_coef_quad),
        .i_coef_lin   (i_coef_lin),
        .i_coef_const (i_coef_const),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_job        (push_job)
    );

    qrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_qstat (qstat)
    );

    qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (pop_job),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_root_count  (o_root_count),
        .o_root_first  (o_root_first),
        .o_root_second (o_root_second),
        .o_overflow    (o_overflow)
    );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of quadratic_root_solver_unit: directed and random equations.
// Depends on qrs_pkg and the solver RTL; a local predictor computes each result not typed in.
`timescale 1ns / 1ps

module tb_top;

    // One predicted or observed solution.
    typedef struct {
        logic [1:0]  cnt;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        ovf;
    } t_sol;

    // One row of the directed table; known rows carry a typed-in solution.
    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          known;
        t_sol        sol;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_coef_quad;
    logic signed [31:0] i_coef_lin;
    logic signed [31:0] i_coef_const;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_root_count;
    logic signed [31:0] o_root_first;
    logic signed [31:0] o_root_second;
    logic               o_overflow;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data;

    t_sol            pending_roots[$];
    longint unsigned tol_now;
    int              idle_pct;
    int              mismatches;
    int              quiet_cycles;
    bit              in_xfer;

    quadratic_root_solver_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_coef_quad  (i_coef_quad),
        .i_coef_lin   (i_coef_lin),
        .i_coef_const (i_coef_const),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_root_count (o_root_count),
        .o_root_first (o_root_first),
        .o_root_second(o_root_second),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? 64'd0 - longint'(x) : x;
    endfunction

    function automatic bit near_zero(longint x);
        longint unsigned m;
        m = mag(x);
        return (m == 0) || (m < tol_now);
    endfunction

    // Floor of the square root of a 64-bit value.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Truncating fixed-point quotient with saturation to 32 bits.
    function automatic logic [31:0] quot_sat(longint num, longint den, inout logic ovf);
        longint unsigned q;
        q = (mag(num) << 16) / mag(den);
        if ((num < 0) != (den < 0)) begin
            if (q > 64'h8000_0000) begin
                q   = 64'h8000_0000;
                ovf = 1'b1;
            end
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF) begin
            q   = 64'h7FFF_FFFF;
            ovf = 1'b1;
        end
        return 32'(q);
    endfunction

    // Expected solution of a*x^2 + b*x + c = 0 under the current tolerance.
    function automatic t_sol solve_roots(logic [31:0] ra, logic [31:0] rb, logic [31:0] rc);
        longint          a, b, c, qd;
        longint unsigned b2, rem, lim, md, rt, t, s;
        bit              fits;
        t_sol            y;
        a = longint'(signed'(ra));
        b = longint'(signed'(rb));
        c = longint'(signed'(rc));
        y = '{cnt: qrs_pkg::CNT_NONE, r1: 32'd0, r2: 32'd0, ovf: 1'b0};
        if (near_zero(a)) begin
            if (near_zero(b)) begin
                y.cnt = near_zero(c) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            end else begin
                y.r1  = quot_sat(-c, b, y.ovf);
                y.cnt = qrs_pkg::CNT_ONE;
            end
            return y;
        end
        // Discriminant kept as 4*qd + rem to stay exact in 64 bits.
        b2  = longint'(b * b);
        qd  = longint'(b2 >> 2) - a * c;
        rem = b2 & 3;
        lim = tol_now << 16;
        if (qd >= 0) begin
            fits = longint'(qd) < (64'd1 <<< 61);
            md   = fits ? (longint'(qd) << 2) + rem : 0;
        end else begin
            fits = mag(qd) < (64'd1 << 61);
            md   = fits ? (mag(qd) << 2) - rem : 0;
        end
        if ((qd == 0 && rem == 0) || (fits && md < lim)) begin
            y.r1  = quot_sat(-b, 2 * a, y.ovf);
            y.r2  = y.r1;
            y.cnt = qrs_pkg::CNT_ONE;
        end else if (qd > 0 || (qd == 0 && rem != 0)) begin
            rt = floor_sqrt(qd);
            t  = rt * rt + rt;
            s  = 2 * rt;
            if (t < qd || (t == qd && rem >= 1)) s = s + 1;
            y.r1  = quot_sat(-b - longint'(s), 2 * a, y.ovf);
            y.r2  = quot_sat(-b + longint'(s), 2 * a, y.ovf);
            y.cnt = qrs_pkg::CNT_TWO;
        end
        return y;
    endfunction

    // Directed equations; typed solutions only where they are obvious.
    t_row dir_tab[18] = '{
        '{32'h0, 32'h0, 32'h0, 1, '{qrs_pkg::CNT_INF, 32'h0, 32'h0, 1'b0}},
        '{32'h0, 32'h0, 32'h0001_0000, 1, '{qrs_pkg::CNT_NONE, 32'h0, 32'h0, 1'b0}},
        '{32'h0001_0000, 32'h0, 32'h0001_0000, 1,
          '{qrs_pkg::CNT_NONE, 32'h0, 32'h0, 1'b0}},
        '{32'h0001_0000, 32'h0, 32'h0, 1, '{qrs_pkg::CNT_ONE, 32'h0, 32'h0, 1'b0}},
        '{32'h0001_0000, 32'h0, 32'hFFFF_0000, 1,
          '{qrs_pkg::CNT_TWO, 32'hFFFF_0000, 32'h0001_0000, 1'b0}},
        '{32'h0, 32'h0001_0000, 32'hFFFE_0000, 1,
          '{qrs_pkg::CNT_ONE, 32'h0002_0000, 32'h0, 1'b0}},
        '{32'h0, 32'h1, 32'h7FFF_FFFF, 1,
          '{qrs_pkg::CNT_ONE, qrs_pkg::ROOT_MIN, 32'h0, 1'b1}},
        '{32'h0, 32'h1, 32'h8000_0000, 1,
          '{qrs_pkg::CNT_ONE, qrs_pkg::ROOT_MAX, 32'h0, 1'b1}},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h1, 32'h7FFF_FFFF, 32'h0, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h0000_8000, 32'h0003_0000, 32'h0004_0000, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h0000_0002, 32'h0000_0003, 32'h0000_0001, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}},
        '{32'h0, 32'h0, 32'h8000_0000, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0}}
    };

    function automatic logic [31:0] with_sign(longint v);
        return 32'($urandom_range(1) ? -v : v);
    endfunction

    // Presents one equation and records its solution once it is transferred.
    task automatic send_eq(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           bit known, t_sol sol);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_coef_quad  <= a;
        i_coef_lin   <= b;
        i_coef_const <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_roots.push_back(known ? sol : solve_roots(a, b, c));
    endtask

    // Random equation, mostly shaped so that real roots and edge cases are frequent.
    task automatic send_random();
        longint s, p, q, k;
        logic [31:0] a, b, c;
        int mode;
        mode = $urandom_range(9);
        s = $urandom_range(255) + 1;
        p = $urandom_range(2047);
        q = $urandom_range(2047);
        k = $urandom_range(1023);
        case (mode)
            0, 1: begin
                a = $urandom();
                b = $urandom();
                c = $urandom();
            end
            2, 3: begin
                p = signed'(with_sign(p));
                q = signed'(with_sign(q));
                a = with_sign(s);
                b = 32'(-signed'(a) * (p + q));
                c = 32'(signed'(a) * p * q);
            end
            4: begin
                k = signed'(with_sign(k));
                a = with_sign($urandom_range(1023) + 1);
                b = 32'(-2 * signed'(a) * k);
                c = 32'(signed'(a) * k * k);
            end
            5: begin
                a = with_sign(tol_now > 0 ? $urandom_range(tol_now) : 0);
                b = $urandom_range(3) == 0 ? with_sign($urandom_range(tol_now)) : $urandom();
                c = $urandom();
            end
            default: begin
                a = with_sign($urandom_range(1 << 20));
                b = with_sign($urandom_range(1 << 20));
                c = with_sign($urandom_range(1 << 20));
            end
        endcase
        send_eq(a, b, c, 0, '{qrs_pkg::CNT_NONE, 0, 0, 0});
    endtask

    // Writes the tolerance once the pipeline has drained.
    task automatic write_tol(logic [15:0] v);
        i_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tol_now = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        repeat (n) send_random();
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        t_sol want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result, count %0d", o_root_count);
            end else begin
                want = pending_roots.pop_front();
                if (want.cnt !== o_root_count || want.r1 !== o_root_first
                        || want.r2 !== o_root_second || want.ovf !== o_overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp %0d %h %h %b got %0d %h %h %b",
                                 want.cnt, want.r1, want.r2, want.ovf, o_root_count,
                                 o_root_first, o_root_second, o_overflow);
                end
            end
        end
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        in_xfer = i_valid && !o_stall;
        if (in_xfer || (o_valid && !i_stall)) quiet_cycles = 0;
        else                                  quiet_cycles++;
        if (quiet_cycles > 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases over several tolerances.
    initial begin
        mismatches   = 0;
        quiet_cycles = 0;
        idle_pct     = 11;
        tol_now      = 1;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_coef_quad  <= '0;
        i_coef_lin   <= '0;
        i_coef_const <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[i])
            send_eq(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, dir_tab[i].known, dir_tab[i].sol);
        random_phase(250);
        write_tol(16'd0);
        random_phase(250);
        write_tol(16'hFFFF);
        random_phase(250);
        write_tol(16'($urandom()));
        random_phase(250);
        // Stretch with no idling on either side.
        write_tol(16'd3);
        idle_pct = 0;
        random_phase(200);
        idle_pct = 11;
        random_phase(100);
        i_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0) $display("Verification passed");
        else                 $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_queue.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver_unit.sv
verif/tb_top.sv
